// File: rtl/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// shared operation codes, status codes and the cell command struct
// ---------------------------------------------------------------------------
package deq_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADINDEX = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // one-hot shift command broadcast to every cell
   typedef struct packed {
      logic add_front;
      logic add_back;
      logic take_front;
      logic insert;
   } cell_cmd_type;

endpackage

// File: rtl/deq_cell.sv
// ---------------------------------------------------------------------------
// deq_cell
// one storage cell of the row: holds, loads, or takes a neighbor's value
// ---------------------------------------------------------------------------
module deq_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                                clock,
   input  deq_pkg::cell_cmd_type               cmd_i,
   input  logic signed [deq_pkg::VALUE_W-1:0]  value_i,
   input  logic        [deq_pkg::POS_W-1:0]    pos_i,
   input  logic        [CNT_W-1:0]             cnt_i,
   input  logic signed [deq_pkg::VALUE_W-1:0]  left_i,
   input  logic signed [deq_pkg::VALUE_W-1:0]  right_i,
   output logic signed [deq_pkg::VALUE_W-1:0]  data_o,
   output logic signed [deq_pkg::VALUE_W-1:0]  tap_o
);
   import deq_pkg::*;

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (cmd_i.add_front) begin
         data_in = (IDX == 0) ? value_i : left_i;
      end else if (cmd_i.add_back) begin
         if (int'(cnt_i) == IDX) data_in = value_i;
      end else if (cmd_i.take_front) begin
         data_in = right_i;
      end else if (cmd_i.insert) begin
         if (int'(pos_i) == IDX) begin
            data_in = value_i;
         end else if (int'(pos_i) < IDX) begin
            data_in = left_i;
         end
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_o = data_ff;
   // back element tap, or-combined in the top level
   assign tap_o  = (int'(cnt_i) == IDX + 1) ? data_ff : '0;

endmodule

// File: rtl/deque_with_positional_insert.sv
// ---------------------------------------------------------------------------
// deque_with_positional_insert
// bounded double-ended queue with insert before a position
// ---------------------------------------------------------------------------
// A row of CAPACITY cells holds the elements, cell 0 being the front. Each
// cell decides from its own index whether to hold, load the new value or
// take a neighbor's value; push-front, pop-front and insert shift the row,
// push-back loads the cell at the count and pop-back leaves the cells alone.
// One transaction may be accepted every cycle while the result side is not
// stalling; each result sits in an output register. Cell contents are not
// cleared by reset or clear; only the count is.
// ---------------------------------------------------------------------------
module deque_with_positional_insert #(
   parameter int CAPACITY = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [deq_pkg::OP_W-1:0]        req_operation,
   input  logic signed [deq_pkg::VALUE_W-1:0]     req_value,
   input  logic        [deq_pkg::POS_W-1:0]       req_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [deq_pkg::VALUE_W-1:0]     rsp_popped_value,
   output logic        [deq_pkg::STATUS_W-1:0]    rsp_status,
   output logic        [deq_pkg::COUNT_W-1:0]     rsp_element_count
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] popped_ff;
   logic signed [VALUE_W-1:0] popped_in;
   logic [STATUS_W-1:0]       status_ff;
   logic [STATUS_W-1:0]       status_in;
   logic [COUNT_W-1:0]        elem_cnt_ff;

   logic                      accept;
   logic                      full;
   logic                      empty;
   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] data  [CAPACITY];
   logic signed [VALUE_W-1:0] tap   [CAPACITY];
   logic signed [VALUE_W-1:0] back_value;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      back_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_value = back_value | tap[i];
      end
   end

   always_comb begin
      cmd       = '0;
      count_in  = count_ff;
      popped_in = '0;
      status_in = ST_OK;
      unique case (req_operation)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.add_front = accept;
               count_in      = count_ff + 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.add_back = accept;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cmd.take_front = accept;
               popped_in      = data[0];
               count_in       = count_ff - 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               popped_in = back_value;
               count_in  = count_ff - 1'b1;
            end
         end
         OP_INSERT: begin
            if (int'(req_position) >= int'(count_ff)) begin
               status_in = ST_BADINDEX;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.insert = accept;
               count_in   = count_ff + 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left;
      logic signed [VALUE_W-1:0] right;
      if (g == 0) begin : g_first
         assign left = req_value;
      end else begin : g_mid_left
         assign left = data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right = data[g];
      end else begin : g_mid_right
         assign right = data[g+1];
      end
      deq_cell #(
         .IDX   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .cmd_i   (cmd),
         .value_i (req_value),
         .pos_i   (req_position),
         .cnt_i   (count_ff),
         .left_i  (left),
         .right_i (right),
         .data_o  (data[g]),
         .tap_o   (tap[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff   <= popped_in;
         status_ff   <= status_in;
         elem_cnt_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_value  = popped_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_count = elem_cnt_ff;

endmodule
